// ===== src/dse_pkg.sv =====
package dse_pkg;

  // Result and target width, fixed by the result format
  localparam int SUM_W = 18;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int NUMBER_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

// ===== src/dse_div.sv =====
module dse_div #(
  parameter int W = dse_pkg::NUMBER_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] rem_r, rem_nxt;

  logic [W:0]   shifted;
  logic [W+1:0] diff;

  // One quotient bit per cycle, restoring scheme
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (diff[W+1]) begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== src/divisor_sum_engine.sv =====
// Divisor sum engine: returns sigma(n), the sum of all positive divisors of n.
//
// Input: present in_number and in_last_in_range with start high; the item is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the result is produced.
// Output: out_valid is high for exactly one cycle with out_divisor_sum,
// out_matches_target and out_last_out. The receiver cannot stall; each result
// is taken in its strobe cycle. Sums above the 18-bit range saturate.
// Configuration: cfg_wr_en with cfg_wr_data writes the target sum; write it
// only while busy is low.
// Operation: candidate divisors d = 1, 2, ... are tried until n / d < d. Each
// candidate passes through the ISSUE and WAIT states, and ACC unless it ends
// the search; WAIT lasts while the bit-serial divider produces one quotient bit
// per cycle. n = 0 skips the divider and goes straight to its result. One item
// at a time; the next one can transfer on the edge that takes the result.
// Reset (rst_n low, synchronous): returns to idle, drops any item in flight
// and clears the target sum to zero.
module divisor_sum_engine #(
  parameter int NUMBER_WIDTH = dse_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [NUMBER_WIDTH-1:0]    in_number,
  input  logic                       in_last_in_range,
  output logic                       out_valid,
  output logic [dse_pkg::SUM_W-1:0]  out_divisor_sum,
  output logic                       out_matches_target,
  output logic                       out_last_out,
  input  logic                       cfg_wr_en,
  input  logic [dse_pkg::SUM_W-1:0]  cfg_wr_data
);

  localparam int W  = NUMBER_WIDTH;
  localparam int SW = dse_pkg::SUM_W;
  localparam int AW = ((W + 1 > SW) ? W + 1 : SW) + 1;

  dse_pkg::state_t state_r, state_nxt;

  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    addend_r, addend_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          last_r, last_nxt;
  logic [SW-1:0] target_r;

  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_sum_r, out_sum_nxt;
  logic          out_match_r, out_match_nxt;
  logic          out_last_r, out_last_nxt;

  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  div_rem;
  logic [AW-1:0] acc_sum;

  dse_div #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dse_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_number == '0) ? dse_pkg::ST_DONE : dse_pkg::ST_ISSUE;
        end
      end
      dse_pkg::ST_ISSUE: state_nxt = dse_pkg::ST_WAIT;
      dse_pkg::ST_WAIT: begin
        if (div_done) begin
          state_nxt = (div_quo < d_r) ? dse_pkg::ST_DONE : dse_pkg::ST_ACC;
        end
      end
      dse_pkg::ST_ACC:  state_nxt = dse_pkg::ST_ISSUE;
      dse_pkg::ST_DONE: state_nxt = dse_pkg::ST_IDLE;
      default:          state_nxt = dse_pkg::ST_IDLE;
    endcase
  end

  assign acc_sum = AW'(sum_r) + AW'(addend_r);

  // Datapath and outputs
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    addend_nxt    = addend_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    div_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_match_nxt = out_match_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      dse_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt    = in_number;
          last_nxt = in_last_in_range;
          d_nxt    = W'(1);
          sum_nxt  = '0;
        end
      end
      dse_pkg::ST_ISSUE: div_start = 1'b1;
      dse_pkg::ST_WAIT: begin
        if (div_done) begin
          if (div_rem != '0) begin
            addend_nxt = '0;
          end else if (div_quo == d_r) begin
            addend_nxt = {1'b0, d_r};
          end else begin
            addend_nxt = {1'b0, d_r} + {1'b0, div_quo};
          end
        end
      end
      dse_pkg::ST_ACC: begin
        // saturate at the top of the result range
        sum_nxt = (acc_sum > AW'(dse_pkg::SUM_MAX)) ? dse_pkg::SUM_MAX : acc_sum[SW-1:0];
        d_nxt   = d_r + 1'b1;
      end
      dse_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = sum_r;
        out_match_nxt = (sum_r == target_r);
        out_last_nxt  = last_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dse_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    addend_r    <= addend_nxt;
    sum_r       <= sum_nxt;
    last_r      <= last_nxt;
    out_sum_r   <= out_sum_nxt;
    out_match_r <= out_match_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy               = (state_r != dse_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_divisor_sum    = out_sum_r;
  assign out_matches_target = out_match_r;
  assign out_last_out       = out_last_r;

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == dse_pkg::ST_WAIT)
    else $error("divider finished outside the wait state");

endmodule
